FILE: hdl/s7if_pkg.sv
// ============================================================================
// s7if_pkg
// Shared constants, types and kernel table of the separable 7-tap blur core.
// ============================================================================
`default_nettype none

package s7if_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int TAPS       = 7;
    localparam int HIST_ROWS  = TAPS - 1;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 16;                 // 255 * 256 fits
    localparam int PROD_W  = 15;                 // 98 * 255 fits
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int COL_W   = 10;
    localparam int ROW_W   = 12;
    localparam int WIDTH_W = 11;
    localparam int HGT_W   = 13;
    localparam int SLOT_W  = 3;
    localparam int CFG_W   = 13;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [HIST_ROWS-1:0][PIX_W-1:0] t_line_taps;

    // item state between the line-store read and the vertical sum
    typedef struct packed {
        logic                vld;
        logic                last;
        logic [SLOT_W-1:0]   slot;
        logic [PIX_W-1:0]    mid;
    } t_stage_b;

    function automatic logic [PIX_W-1:0] coef(input logic [SLOT_W-1:0] idx);
        logic [PIX_W-1:0] c;
        case (idx)
            3'd0:    c = 8'd2;
            3'd1:    c = 8'd15;
            3'd2:    c = 8'd62;
            3'd3:    c = 8'd98;
            3'd4:    c = 8'd62;
            3'd5:    c = 8'd15;
            3'd6:    c = 8'd2;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/s7if_hcell.sv
// ============================================================================
// s7if_hcell
// One cell of the transposed horizontal FIR: adds its tap product to the
// partial sum handed over by its neighbor and holds the result.
// ============================================================================
`default_nettype none

module s7if_hcell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic [s7if_pkg::PIX_W-1:0] i_coef,
    input  wire logic [s7if_pkg::PIX_W-1:0] i_pixel,
    input  wire logic [s7if_pkg::SUM_W-1:0] i_psum,
    output logic      [s7if_pkg::SUM_W-1:0] o_psum
);

    logic [s7if_pkg::SUM_W-1:0] r_psum;
    logic [s7if_pkg::SUM_W-1:0] n_psum;

    always_comb begin
        n_psum = i_psum + s7if_pkg::SUM_W'(i_coef) * s7if_pkg::SUM_W'(i_pixel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum <= '0;
        end else if (i_en) begin
            r_psum <= n_psum;
        end
    end

    assign o_psum = r_psum;

endmodule

`default_nettype wire

FILE: hdl/s7if_lcell.sv
// ============================================================================
// s7if_lcell
// One line-store row: intermediate bytes of one earlier row, one write and
// one registered read per cycle, read-before-write at the same address.
// ============================================================================
`default_nettype none

module s7if_lcell (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic                        i_we,
    input  wire logic [s7if_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [s7if_pkg::PIX_W-1:0]  i_wdata,
    output logic      [s7if_pkg::PIX_W-1:0]  o_rdata
);

    logic [s7if_pkg::PIX_W-1:0] r_mem [s7if_pkg::MAX_WIDTH];
    logic [s7if_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/s7if_vsum.sv
// ============================================================================
// s7if_vsum
// Vertical filter: lines up the six stored rows by ring slot, registers the
// tap products, then sums, scales and holds the result for the output side.
// ============================================================================
`default_nettype none

module s7if_vsum (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire s7if_pkg::t_stage_b          i_b,
    input  wire s7if_pkg::t_line_taps        i_rdata,
    output logic                             o_valid,
    output logic                             o_last,
    output logic      [s7if_pkg::PIX_W-1:0]  o_pixel
);

    logic [s7if_pkg::TAPS-1:0][s7if_pkg::PROD_W-1:0] n_prod;
    logic [s7if_pkg::TAPS-1:0][s7if_pkg::PROD_W-1:0] r_prod;
    logic                                            r_c_vld;
    logic                                            r_c_last;
    logic [s7if_pkg::SUM_W-1:0]                      n_sum;
    logic                                            r_o_vld;
    logic                                            r_o_last;
    logic [s7if_pkg::PIX_W-1:0]                      r_o_pix;

    // tap i reads ring slot (slot + i) mod 6, oldest row first
    always_comb begin
        logic [s7if_pkg::SLOT_W:0] idx;
        for (int i = 0; i < s7if_pkg::HIST_ROWS; i++) begin
            idx = {1'b0, i_b.slot} + (s7if_pkg::SLOT_W + 1)'(i);
            if (idx >= (s7if_pkg::SLOT_W + 1)'(s7if_pkg::HIST_ROWS)) begin
                idx = idx - (s7if_pkg::SLOT_W + 1)'(s7if_pkg::HIST_ROWS);
            end
            n_prod[i] = s7if_pkg::PROD_W'(s7if_pkg::coef(s7if_pkg::SLOT_W'(i)))
                      * s7if_pkg::PROD_W'(i_rdata[idx[s7if_pkg::SLOT_W-1:0]]);
        end
        n_prod[s7if_pkg::TAPS-1] =
            s7if_pkg::PROD_W'(s7if_pkg::coef(s7if_pkg::SLOT_W'(s7if_pkg::TAPS - 1)))
          * s7if_pkg::PROD_W'(i_b.mid);
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < s7if_pkg::TAPS; i++) begin
            n_sum = n_sum + s7if_pkg::SUM_W'(r_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_adv) begin
            r_c_vld <= i_b.vld;
            r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod   <= n_prod;
            r_c_last <= i_b.last;
            r_o_pix  <= n_sum[s7if_pkg::SUM_W-1 -: s7if_pkg::PIX_W];
            r_o_last <= r_c_last;
        end
    end

    assign o_valid = r_o_vld;
    assign o_last  = r_o_last;
    assign o_pixel = r_o_pix;

endmodule

`default_nettype wire

FILE: hdl/separable_7tap_image_filter_core.sv
// ============================================================================
// separable_7tap_image_filter_core
// 7x7 separable blur (2,15,62,98,62,15,2 / 256 each way) over a
// raster-order 8-bit pixel stream, one output per full 7x7 window.
// ============================================================================
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] pixel_in
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[7:0] pixel_out, tlast frame_end
//  cfg       in   i_cfg_we                      i_cfg_index, i_cfg_data
//
//  One item per clock while no untaken output result stalls it. A result
//  passes the line-store read, product register and output register, in order.
//  The horizontal filter is a chain of six partial-sum cells; the six line
//  stores are one 1024 x 8 RAM each, one read and one write per cycle.
//  The whole pipeline freezes only while the output register holds an untaken
//  result. Reset clears counters, cells and valids; line stores are not cleared.
//
`default_nettype none

module separable_7tap_image_filter_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // [7:0] pixel_in
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [7:0]                  m_axis_tdata,   // [7:0] pixel_out
    output logic                             m_axis_tlast,   // frame_end
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [s7if_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int HR = s7if_pkg::HIST_ROWS;

    logic [s7if_pkg::WIDTH_W-1:0] r_width;
    logic [s7if_pkg::HGT_W-1:0]   r_height;
    logic [s7if_pkg::WIDTH_W-1:0] w_eff;
    logic [s7if_pkg::HGT_W-1:0]   h_eff;

    logic [s7if_pkg::COL_W-1:0]   r_col;
    logic [s7if_pkg::ROW_W-1:0]   r_row;
    logic [s7if_pkg::SLOT_W-1:0]  r_slot;

    logic                         adv;
    logic                         accept;
    logic                         col_last;
    logic                         row_last;
    logic                         h_out;
    logic                         produce;
    logic [s7if_pkg::ADDR_W-1:0]  x_addr;

    logic [HR:0][s7if_pkg::SUM_W-1:0] psum;
    logic [s7if_pkg::SUM_W-1:0]   mid_sum;
    logic [s7if_pkg::PIX_W-1:0]   mid;

    s7if_pkg::t_line_taps         rdata;
    s7if_pkg::t_stage_b           r_b;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= s7if_pkg::WIDTH_W'(s7if_pkg::MAX_WIDTH);
            r_height <= s7if_pkg::HGT_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                s7if_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[s7if_pkg::WIDTH_W-1:0];
                s7if_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data[s7if_pkg::HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width < s7if_pkg::WIDTH_W'(s7if_pkg::TAPS)) begin
            w_eff = s7if_pkg::WIDTH_W'(s7if_pkg::TAPS);
        end else if (r_width > s7if_pkg::WIDTH_W'(s7if_pkg::MAX_WIDTH)) begin
            w_eff = s7if_pkg::WIDTH_W'(s7if_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height < s7if_pkg::HGT_W'(s7if_pkg::TAPS)) begin
            h_eff = s7if_pkg::HGT_W'(s7if_pkg::TAPS);
        end else if (r_height > s7if_pkg::HGT_W'(s7if_pkg::MAX_HEIGHT)) begin
            h_eff = s7if_pkg::HGT_W'(s7if_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // ---------------- handshake and position ----------------
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    always_comb begin
        col_last = ({1'b0, r_col} + s7if_pkg::WIDTH_W'(1)) >= w_eff;
        row_last = ({1'b0, r_row} + s7if_pkg::HGT_W'(1)) >= h_eff;
        h_out    = r_col >= s7if_pkg::COL_W'(HR);
        produce  = h_out && (r_row >= s7if_pkg::ROW_W'(HR));
        x_addr   = s7if_pkg::ADDR_W'(r_col - s7if_pkg::COL_W'(HR));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + s7if_pkg::ROW_W'(1);
                    r_slot <= (r_slot == s7if_pkg::SLOT_W'(HR - 1)) ? '0
                                                                    : r_slot + 3'd1;
                end
            end else begin
                r_col <= r_col + s7if_pkg::COL_W'(1);
            end
        end
    end

    // ---------------- horizontal filter: chain of partial-sum cells ----------------
    assign psum[HR] = '0;

    for (genvar j = 0; j < HR; j++) begin : g_hcell
        s7if_hcell u_hcell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (accept),
            .i_coef  (s7if_pkg::coef(s7if_pkg::SLOT_W'(HR - 1 - j))),
            .i_pixel (s_axis_tdata),
            .i_psum  (psum[j+1]),
            .o_psum  (psum[j])
        );
    end

    always_comb begin
        mid_sum = psum[0] + s7if_pkg::SUM_W'(s7if_pkg::coef(s7if_pkg::SLOT_W'(HR)))
                          * s7if_pkg::SUM_W'(s_axis_tdata);
        mid     = mid_sum[s7if_pkg::SUM_W-1 -: s7if_pkg::PIX_W];
    end

    // ---------------- line stores, one per ring slot ----------------
    for (genvar k = 0; k < HR; k++) begin : g_lcell
        s7if_lcell u_lcell (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_we    (accept && h_out && (r_slot == s7if_pkg::SLOT_W'(k))),
            .i_addr  (x_addr),
            .i_wdata (mid),
            .o_rdata (rdata[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
        end else if (adv) begin
            r_b.vld  <= accept && produce;
            r_b.last <= col_last && row_last;
            r_b.slot <= r_slot;
            r_b.mid  <= mid;
        end
    end

    // ---------------- vertical filter and output register ----------------
    s7if_vsum u_vsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_b     (r_b),
        .i_rdata (rdata),
        .o_valid (m_axis_tvalid),
        .o_last  (m_axis_tlast),
        .o_pixel (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= s7if_pkg::SLOT_W'(HR - 1))
        else $error("ring slot out of range");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && col_last && row_last |=> r_col == '0 && r_row == '0 && r_slot == '0)
        else $error("position counters did not restart after frame end");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !(accept && produce) |=> !r_b.vld)
        else $error("item entered vertical stage without a full window");

    a_row_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && col_last && !row_last && r_slot == s7if_pkg::SLOT_W'(HR - 1)
        |=> r_slot == '0)
        else $error("ring slot did not wrap after six rows");
`endif

endmodule

`default_nettype wire
